FILE: sv/rrcu_pkg.sv
package rrcu_pkg;

  localparam int WORD_BITS = 64;
  localparam int MAG_BITS  = WORD_BITS;
  localparam int HALF_BITS = MAG_BITS / 2;
  localparam int PROD_BITS = 2 * MAG_BITS;

  typedef enum logic [1:0] {
    MODE_REDUCE = 2'd0,
    MODE_NEGATE = 2'd1,
    MODE_RECIP  = 2'd2,
    MODE_CMP    = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD_START,
    ST_GCD_DIV,
    ST_GCD_STEP,
    ST_QN_START,
    ST_QN_DIV,
    ST_QD_START,
    ST_QD_DIV,
    ST_MUL_P,
    ST_MUL_Q,
    ST_DONE
  } state_t;

  // Control between the sequencer and the divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [MAG_BITS-1:0] mag_of(input logic [MAG_BITS-1:0] v);
    mag_of = v[MAG_BITS-1] ? (~v + MAG_BITS'(1)) : v;
  endfunction

endpackage

FILE: sv/rrcu_div.sv
module rrcu_div
  import rrcu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  div_ctrl_t           ctrl,
  input  logic [MAG_BITS-1:0] dividend,
  input  logic [MAG_BITS-1:0] divisor,
  output div_stat_t           stat,
  output logic [MAG_BITS-1:0] quotient,
  output logic [MAG_BITS-1:0] remainder
);

  localparam int CNT_BITS = $clog2(MAG_BITS + 1);

  logic [CNT_BITS-1:0] count;
  logic                busy;
  logic                done;
  logic [MAG_BITS-1:0] quo;
  logic [MAG_BITS:0]   rem;
  logic [MAG_BITS-1:0] dvs;
  logic [MAG_BITS:0]   trial;
  logic [MAG_BITS:0]   shifted;

  // One restoring step a cycle: shift in a dividend bit, subtract if it fits.
  always_comb begin
    shifted = {rem[MAG_BITS-1:0], quo[MAG_BITS-1]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        count <= CNT_BITS'(MAG_BITS);
      end else if (busy) begin
        count <= count - CNT_BITS'(1);
        if (count == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[MAG_BITS]) begin
        rem <= trial;
        quo <= {quo[MAG_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[MAG_BITS-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem[MAG_BITS-1:0];

endmodule

FILE: sv/rational_reduce_compare_unit.sv
// Reduce runs Euclid steps, then the two quotients, all on one shared 64-step divider;
//   zero over zero skips the divider and raises fault; negate and reciprocal go straight
//   to the finishing state; compare forms eight 32x32 partial products on one shared
//   multiplier, then compares.
// Throughput: one item at a time; s_tready is low while an item is in work or its result waits.
// Reset: rst is synchronous, active high, and clears the sequencer and the output valid.
module rational_reduce_compare_unit
  import rrcu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // mode[1:0], first_num[65:2], first_den[129:66], second_num[193:130],
  // second_den[257:194], zero fill to 264 bits
  input  logic [263:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_num[63:0], result_den[127:64], equal[128], less[129], greater[130],
  // fault[131], zero fill to 136 bits
  output logic [135:0] m_tdata
);

  state_t state, state_next;

  mode_t               mode;
  logic [MAG_BITS-1:0] n1, d1, n2, d2;
  logic [MAG_BITS-1:0] ga, gb;
  logic [MAG_BITS-1:0] rnum, rden;
  logic                feq, flt, fgt, ffault;
  logic [PROD_BITS-1:0] pprod, qprod;
  logic                out_valid;

  div_ctrl_t           dctrl;
  div_stat_t           dstat;
  logic [MAG_BITS-1:0] div_a, div_b, div_q, div_r;

  // Shared multiplier: one 32x32 partial product per cycle, four per cross product.
  logic [MAG_BITS-1:0]  mul_a, mul_b;
  logic                 mul_neg;
  logic [1:0]           mcnt;
  logic [PROD_BITS-1:0] macc;
  logic [HALF_BITS-1:0] a_half, b_half;
  logic [MAG_BITS-1:0]  part;
  logic [PROD_BITS-1:0] pshift, msum, mul_signed;

  logic accept_in;
  assign accept_in = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE) && !out_valid;

  rrcu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (dctrl),
    .dividend  (div_a),
    .divisor   (div_b),
    .stat      (dstat),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept_in) begin
          unique case (mode_t'(s_tdata[1:0]))
            MODE_REDUCE: state_next = ST_GCD_START;
            MODE_CMP:    state_next = ST_MUL_P;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_GCD_START: state_next = (gb == '0) ? ST_QN_START : ST_GCD_DIV;
      ST_GCD_DIV:   if (dstat.done) state_next = ST_GCD_STEP;
      ST_GCD_STEP:  state_next = ST_GCD_START;
      ST_QN_START:  state_next = (ga == '0) ? ST_DONE : ST_QN_DIV;
      ST_QN_DIV:    if (dstat.done) state_next = ST_QD_START;
      ST_QD_START:  state_next = ST_QD_DIV;
      ST_QD_DIV:    if (dstat.done) state_next = ST_DONE;
      ST_MUL_P:     if (mcnt == 2'd3) state_next = ST_MUL_Q;
      ST_MUL_Q:     if (mcnt == 2'd3) state_next = ST_DONE;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Divider operands and start
  always_comb begin
    dctrl.start = 1'b0;
    div_a       = ga;
    div_b       = gb;
    unique case (state)
      ST_GCD_START: dctrl.start = (gb != '0);
      ST_QN_START: begin
        dctrl.start = (ga != '0);
        div_a       = mag_of(n1);
        div_b       = ga;
      end
      ST_QD_START: begin
        dctrl.start = 1'b1;
        div_a       = mag_of(d1);
        div_b       = ga;
      end
      default: ;
    endcase
  end

  // Multiplier operands: P = n1*d2 first, then Q = d1*n2; pick halves by partial count
  always_comb begin
    if (state == ST_MUL_Q) begin
      mul_a   = mag_of(d1);
      mul_b   = mag_of(n2);
      mul_neg = d1[MAG_BITS-1] ^ n2[MAG_BITS-1];
    end else begin
      mul_a   = mag_of(n1);
      mul_b   = mag_of(d2);
      mul_neg = n1[MAG_BITS-1] ^ d2[MAG_BITS-1];
    end
    a_half = mcnt[1] ? mul_a[MAG_BITS-1:HALF_BITS] : mul_a[HALF_BITS-1:0];
    b_half = mcnt[0] ? mul_b[MAG_BITS-1:HALF_BITS] : mul_b[HALF_BITS-1:0];
    part   = MAG_BITS'(a_half) * MAG_BITS'(b_half);
    if (mcnt == 2'd0) begin
      pshift = {{MAG_BITS{1'b0}}, part};
    end else if (mcnt == 2'd3) begin
      pshift = {part, {MAG_BITS{1'b0}}};
    end else begin
      pshift = {{HALF_BITS{1'b0}}, part, {HALF_BITS{1'b0}}};
    end
    msum       = macc + pshift;
    mul_signed = mul_neg ? (~msum + PROD_BITS'(1)) : msum;
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept_in) begin
          mode   <= mode_t'(s_tdata[1:0]);
          n1     <= s_tdata[65:2];
          d1     <= s_tdata[129:66];
          n2     <= s_tdata[193:130];
          d2     <= s_tdata[257:194];
          ga     <= mag_of(s_tdata[65:2]);
          gb     <= mag_of(s_tdata[129:66]);
          feq    <= 1'b0;
          flt    <= 1'b0;
          fgt    <= 1'b0;
          ffault <= 1'b0;
          rnum   <= '0;
          rden   <= '0;
          mcnt   <= '0;
          macc   <= '0;
        end
      end
      ST_GCD_STEP: begin
        ga <= gb;
        gb <= div_r;
      end
      ST_QN_START: begin
        if (ga == '0) begin
          rnum   <= n1;
          rden   <= d1;
          ffault <= 1'b1;
        end
      end
      ST_QN_DIV: begin
        if (dstat.done) rnum <= n1[MAG_BITS-1] ? (~div_q + MAG_BITS'(1)) : div_q;
      end
      ST_QD_DIV: begin
        if (dstat.done) rden <= d1[MAG_BITS-1] ? (~div_q + MAG_BITS'(1)) : div_q;
      end
      ST_MUL_P: begin
        mcnt <= mcnt + 2'd1;
        if (mcnt == 2'd3) begin
          pprod <= mul_signed;
          macc  <= '0;
        end else begin
          macc  <= msum;
        end
      end
      ST_MUL_Q: begin
        mcnt <= mcnt + 2'd1;
        if (mcnt == 2'd3) begin
          qprod <= mul_signed;
          macc  <= '0;
        end else begin
          macc  <= msum;
        end
      end
      ST_DONE: begin
        unique case (mode)
          MODE_NEGATE: begin
            rnum <= ~n1 + MAG_BITS'(1);
            rden <= d1;
          end
          MODE_RECIP: begin
            rnum <= d1;
            rden <= n1;
          end
          MODE_CMP: begin
            feq <= (pprod == qprod);
            flt <= $signed(pprod) < $signed(qprod);
            fgt <= $signed(pprod) > $signed(qprod);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, ffault, fgt, flt, feq, rden, rnum};

`ifndef SYNTHESIS
  // Never ready while an item is in work.
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready) else $error("ready during work");

  // A result leaves the sequencer only from the finishing state.
  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE)) else $error("stray result");

  // Compare flags are mutually exclusive.
  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({feq, flt, fgt})) else $error("compare flags clash");

  // The divider runs only in a division state.
  a_div_states: assert property (@(posedge clk) disable iff (rst)
    dstat.busy |-> (state == ST_GCD_DIV || state == ST_QN_DIV || state == ST_QD_DIV))
    else $error("divider busy outside division");
`endif

endmodule
